// ===== rtl/mbt_pkg.sv =====
// Shared types and constants for the model bounds transform unit.
// Used by every module of the block; depends on nothing else.
package mbt_pkg;

	// Default datapath parameters
	localparam int COORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int EW_CAP         = 46;

	// Fixed field widths
	localparam int IO_W      = 32;
	localparam int TRIG_W    = 18;
	localparam int CFG_IDX_W = 3;

	// Command queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE = 3'd0,
		REG_OFF_X = 3'd1,
		REG_OFF_Y = 3'd2,
		REG_OFF_Z = 3'd3,
		REG_COS   = 3'd4,
		REG_SIN   = 3'd5
	} reg_idx_t;

	// Register reset values
	localparam logic signed [IO_W-1:0]   SCALE_RST = 32'sd3277;
	localparam logic signed [IO_W-1:0]   OFF_X_RST = 32'sd0;
	localparam logic signed [IO_W-1:0]   OFF_Y_RST = -32'sd13107;
	localparam logic signed [IO_W-1:0]   OFF_Z_RST = -32'sd58982;
	localparam logic signed [TRIG_W-1:0] COS_RST   = 18'sd0;
	localparam logic signed [TRIG_W-1:0] SIN_RST   = 18'sd65536;

	typedef struct packed {
		logic signed [IO_W-1:0]   scale;
		logic signed [IO_W-1:0]   off_x;
		logic signed [IO_W-1:0]   off_y;
		logic signed [IO_W-1:0]   off_z;
		logic signed [TRIG_W-1:0] rot_cos;
		logic signed [TRIG_W-1:0] rot_sin;
	} cfg_t;

	// One queued command: a vertex, a close, or both
	typedef struct packed {
		logic signed [IO_W-1:0] vx;
		logic signed [IO_W-1:0] vy;
		logic signed [IO_W-1:0] vz;
		logic                   vert;
		logic                   last;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic signed [IO_W-1:0] min_x;
		logic signed [IO_W-1:0] min_y;
		logic signed [IO_W-1:0] min_z;
		logic signed [IO_W-1:0] max_x;
		logic signed [IO_W-1:0] max_y;
		logic signed [IO_W-1:0] max_z;
		logic signed [IO_W-1:0] ctr_x;
		logic signed [IO_W-1:0] ctr_y;
		logic signed [IO_W-1:0] ctr_z;
		logic                   used_default;
	} res_t;

endpackage

// ===== rtl/model_bounds_transform_unit.sv =====
// Bounding box of transformed model vertices.
// Each input transaction may carry one Q16.16 vertex and/or close a model.
// A vertex is scaled, offset per axis and rotated about Y, then folded into
// a running min/max box per axis. The transaction that closes a model emits
// one result transaction with min, max and center; a model with no vertex
// gives the box of plus or minus one half with zero center (used_default).
// Channels: input and output use valid/stall; configuration writes use
// cfg_valid/cfg_ready (always ready) and should land only while idle.
// Throughput: one item per cycle while the output is not stalled; the front
// register, a four-entry command queue and the six-stage back pipeline (two
// multiply stages) set it. A closing item passes the front register, the queue
// and each back stage in turn before its result is valid on the output.
// A stall on a valid output freezes the whole back pipeline; the queue then
// fills, and in_stall rises once four items are queued and a fifth waits
// in the front register.
// Reset empties the pipe and queue, clears the box and loads the register
// defaults. Depends on mbt_pkg, mbt_front, mbt_fifo and mbt_back.
module model_bounds_transform_unit import mbt_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [IO_W-1:0] vertex_x,
	input  logic signed [IO_W-1:0] vertex_y,
	input  logic signed [IO_W-1:0] vertex_z,
	input  logic                   has_vertex,
	input  logic                   last_item,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [IO_W-1:0] min_x,
	output logic signed [IO_W-1:0] min_y,
	output logic signed [IO_W-1:0] min_z,
	output logic signed [IO_W-1:0] max_x,
	output logic signed [IO_W-1:0] max_y,
	output logic signed [IO_W-1:0] max_z,
	output logic signed [IO_W-1:0] center_x,
	output logic signed [IO_W-1:0] center_y,
	output logic signed [IO_W-1:0] center_z,
	output logic                   used_default,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [IO_W-1:0]        cfg_data
);

	cfg_t    cfg_q;
	item_t   item_in;
	item_t   push_item;
	item_t   head;
	q_stat_t q_stat;
	logic    push;
	logic    pop;
	res_t    res;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale   <= SCALE_RST;
			cfg_q.off_x   <= OFF_X_RST;
			cfg_q.off_y   <= OFF_Y_RST;
			cfg_q.off_z   <= OFF_Z_RST;
			cfg_q.rot_cos <= COS_RST;
			cfg_q.rot_sin <= SIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_SCALE: cfg_q.scale   <= cfg_data;
				REG_OFF_X: cfg_q.off_x   <= cfg_data;
				REG_OFF_Y: cfg_q.off_y   <= cfg_data;
				REG_OFF_Z: cfg_q.off_z   <= cfg_data;
				REG_COS:   cfg_q.rot_cos <= cfg_data[TRIG_W-1:0];
				REG_SIN:   cfg_q.rot_sin <= cfg_data[TRIG_W-1:0];
				default:   ;
			endcase
		end
	end

	// Pack the input transaction
	always_comb begin
		item_in.vx   = vertex_x;
		item_in.vy   = vertex_y;
		item_in.vz   = vertex_z;
		item_in.vert = has_vertex;
		item_in.last = last_item;
	end

	mbt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item_in  (item_in),
		.q_stat   (q_stat),
		.push     (push),
		.item_out (push_item)
	);

	mbt_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (push_item),
		.pop     (pop),
		.head    (head),
		.q_stat  (q_stat)
	);

	mbt_back #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.cfg       (cfg_q),
		.out_stall (out_stall),
		.res_valid (out_valid),
		.res       (res)
	);

	// Unpack the result transaction
	assign min_x        = res.min_x;
	assign min_y        = res.min_y;
	assign min_z        = res.min_z;
	assign max_x        = res.max_x;
	assign max_y        = res.max_y;
	assign max_z        = res.max_z;
	assign center_x     = res.ctr_x;
	assign center_y     = res.ctr_y;
	assign center_z     = res.ctr_z;
	assign used_default = res.used_default;

	// The front holds off only when the queue is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_stat.full)
		else $error("in_stall raised with room in the command queue");

	// A default box is symmetric about zero
	a_default_box: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && used_default) |->
		(center_x == '0 && center_y == '0 && center_z == '0 &&
		min_x == -max_x && min_y == -max_y && min_z == -max_z))
		else $error("default box is malformed");

	// A write to the X offset lands in the next cycle
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == REG_OFF_X) |=>
		(cfg_q.off_x == $past(cfg_data)))
		else $error("X offset write lost");

endmodule

// ===== rtl/mbt_front.sv =====
// Input front end: accepts transactions, drops items that neither carry
// a vertex nor close a model, and pushes the rest into the command queue.
// Depends on mbt_pkg.
module mbt_front import mbt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  item_t   item_in,
	input  q_stat_t q_stat,
	output logic    push,
	output item_t   item_out
);

	logic  hold_valid_q;
	item_t hold_q;

	// Hold while the queue is full
	assign in_stall = hold_valid_q && q_stat.full;
	assign push     = hold_valid_q && !q_stat.full;
	assign item_out = hold_q;

	// Classify: keep only items with an effect
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (!in_stall) begin
			hold_valid_q <= in_valid && (item_in.vert || item_in.last);
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			hold_q <= item_in;
		end
	end

endmodule

// ===== rtl/mbt_fifo.sv =====
// Short command queue decoupling the front end from the transform back end.
// Depends on mbt_pkg.
module mbt_fifo import mbt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   wr_item,
	input  logic    pop,
	output item_t   head,
	output q_stat_t q_stat
);

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_stat.empty = (count_q == '0);

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// ===== rtl/mbt_back.sv =====
// Transform back end: scale, offset, Y rotation, min/max accumulation and
// result formation, as a stalling pipeline fed from the command queue.
// Depends on mbt_pkg.
module mbt_back import mbt_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   head,
	input  q_stat_t q_stat,
	output logic    pop,
	input  cfg_t    cfg,
	input  logic    out_stall,
	output logic    res_valid,
	output res_t    res
);

	localparam int EW  = (COORD_BITS > EW_CAP) ? EW_CAP : COORD_BITS;
	localparam int PW1 = 2 * IO_W;
	localparam int XW  = (EW > IO_W) ? EW : IO_W;
	localparam int AW  = XW + 1;
	localparam int PW2 = EW + TRIG_W;
	localparam int DW  = PW2 + 1;
	localparam logic signed [EW-1:0] CMAX = {1'b0, {(EW-1){1'b1}}};
	localparam logic signed [EW-1:0] CMIN = {1'b1, {(EW-1){1'b0}}};
	localparam logic [IO_W-1:0] DEF_HI = IO_W'(1) << (FRAC_BITS - 1);
	localparam logic [IO_W-1:0] DEF_LO = IO_W'(0) - DEF_HI;

	// Saturate a scaled product to the coordinate range
	function automatic logic signed [EW-1:0] sat_p(input logic signed [PW1-1:0] v);
		logic [PW1-EW:0] hi_bits;
		hi_bits = v[PW1-1:EW-1];
		if (&hi_bits || ~|hi_bits) return v[EW-1:0];
		return v[PW1-1] ? CMIN : CMAX;
	endfunction

	// Saturate an offset sum
	function automatic logic signed [EW-1:0] sat_a(input logic signed [AW-1:0] v);
		logic [AW-EW:0] hi_bits;
		hi_bits = v[AW-1:EW-1];
		if (&hi_bits || ~|hi_bits) return v[EW-1:0];
		return v[AW-1] ? CMIN : CMAX;
	endfunction

	// Saturate a rotated coordinate
	function automatic logic signed [EW-1:0] sat_d(input logic signed [DW-1:0] v);
		logic [DW-EW:0] hi_bits;
		hi_bits = v[DW-1:EW-1];
		if (&hi_bits || ~|hi_bits) return v[EW-1:0];
		return v[DW-1] ? CMIN : CMAX;
	endfunction

	// Low output bits of a coordinate
	function automatic logic [IO_W-1:0] to_io(input logic signed [EW-1:0] v);
		logic signed [XW-1:0] w;
		w = XW'(v);
		return w[IO_W-1:0];
	endfunction

	logic adv;

	logic                   v_s1, vert_s1, last_s1;
	logic signed [PW1-1:0]  px_s1, py_s1, pz_s1;
	logic                   v_s2, vert_s2, last_s2;
	logic signed [EW-1:0]   x_s2, y_s2, z_s2;
	logic                   v_s3, vert_s3, last_s3;
	logic signed [PW2-1:0]  xc_s3, zs_s3, xs_s3, zc_s3;
	logic signed [EW-1:0]   y_s3;
	logic                   v_s4, vert_s4, last_s4;
	logic signed [EW-1:0]   rx_s4, y_s4, rz_s4;
	logic                   v_s5, seen_s5;
	logic signed [EW-1:0]   lo_s5 [3];
	logic signed [EW-1:0]   hi_s5 [3];

	logic signed [EW-1:0]   lo_q [3];
	logic signed [EW-1:0]   hi_q [3];
	logic                   seen_q;

	logic signed [EW-1:0]   pt [3];
	logic signed [EW-1:0]   lo_n [3];
	logic signed [EW-1:0]   hi_n [3];
	logic                   seen_n;
	logic signed [EW:0]     ctr_sum [3];
	logic signed [EW-1:0]   ctr [3];
	logic signed [AW-1:0]   sum_x, sum_y, sum_z;
	logic signed [DW-1:0]   dx, dz;
	res_t                   res_d;

	// Move the whole pipe unless the result register is stalled
	assign adv = !(res_valid && out_stall);
	assign pop = adv && !q_stat.empty;

	// Stage valids and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vert_s1 <= head.vert;
			last_s1 <= head.last;
			vert_s2 <= vert_s1;
			last_s2 <= last_s1;
			vert_s3 <= vert_s2;
			last_s3 <= last_s2;
			vert_s4 <= vert_s3;
			last_s4 <= last_s3;
		end
	end

	// Stage 1: scale products
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1 <= PW1'($signed(head.vx)) * PW1'($signed(cfg.scale));
			py_s1 <= PW1'($signed(head.vy)) * PW1'($signed(cfg.scale));
			pz_s1 <= PW1'($signed(head.vz)) * PW1'($signed(cfg.scale));
		end
	end

	// Stage 2: truncate, saturate, add offsets
	always_comb begin
		sum_x = AW'(sat_p(px_s1 >>> FRAC_BITS)) + AW'($signed(cfg.off_x));
		sum_y = AW'(sat_p(py_s1 >>> FRAC_BITS)) + AW'($signed(cfg.off_y));
		sum_z = AW'(sat_p(pz_s1 >>> FRAC_BITS)) + AW'($signed(cfg.off_z));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2 <= sat_a(sum_x);
			y_s2 <= sat_a(sum_y);
			z_s2 <= sat_a(sum_z);
		end
	end

	// Stage 3: rotation products
	always_ff @(posedge clk) begin
		if (adv) begin
			xc_s3 <= PW2'(x_s2) * PW2'($signed(cfg.rot_cos));
			zs_s3 <= PW2'(z_s2) * PW2'($signed(cfg.rot_sin));
			xs_s3 <= PW2'(x_s2) * PW2'($signed(cfg.rot_sin));
			zc_s3 <= PW2'(z_s2) * PW2'($signed(cfg.rot_cos));
			y_s3  <= y_s2;
		end
	end

	// Stage 4: combine, truncate, saturate
	always_comb begin
		dx = DW'(xc_s3) - DW'(zs_s3);
		dz = DW'(xs_s3) + DW'(zc_s3);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_s4 <= sat_d(dx >>> FRAC_BITS);
			rz_s4 <= sat_d(dz >>> FRAC_BITS);
			y_s4  <= y_s3;
		end
	end

	// Stage 5: running box update
	always_comb begin
		pt[0]  = rx_s4;
		pt[1]  = y_s4;
		pt[2]  = rz_s4;
		seen_n = seen_q || vert_s4;
		for (int i = 0; i < 3; i++) begin
			lo_n[i] = lo_q[i];
			hi_n[i] = hi_q[i];
			if (vert_s4 && (pt[i] < lo_q[i])) begin
				lo_n[i] = pt[i];
			end
			if (vert_s4 && (pt[i] > hi_q[i])) begin
				hi_n[i] = pt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				lo_q[i] <= CMAX;
				hi_q[i] <= CMIN;
			end
			seen_q <= 1'b0;
			v_s5   <= 1'b0;
		end else if (adv) begin
			v_s5 <= v_s4 && last_s4;
			if (v_s4 && last_s4) begin
				for (int i = 0; i < 3; i++) begin
					lo_q[i] <= CMAX;
					hi_q[i] <= CMIN;
				end
				seen_q <= 1'b0;
			end else if (v_s4) begin
				lo_q   <= lo_n;
				hi_q   <= hi_n;
				seen_q <= seen_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_s5   <= lo_n;
			hi_s5   <= hi_n;
			seen_s5 <= seen_n;
		end
	end

	// Result: centers, default box, output register
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ctr_sum[i] = (EW + 1)'(lo_s5[i]) + (EW + 1)'(hi_s5[i]);
			ctr[i]     = EW'(ctr_sum[i] >>> 1);
		end
		if (seen_s5) begin
			res_d.min_x        = to_io(lo_s5[0]);
			res_d.min_y        = to_io(lo_s5[1]);
			res_d.min_z        = to_io(lo_s5[2]);
			res_d.max_x        = to_io(hi_s5[0]);
			res_d.max_y        = to_io(hi_s5[1]);
			res_d.max_z        = to_io(hi_s5[2]);
			res_d.ctr_x        = to_io(ctr[0]);
			res_d.ctr_y        = to_io(ctr[1]);
			res_d.ctr_z        = to_io(ctr[2]);
			res_d.used_default = 1'b0;
		end else begin
			res_d.min_x        = DEF_LO;
			res_d.min_y        = DEF_LO;
			res_d.min_z        = DEF_LO;
			res_d.max_x        = DEF_HI;
			res_d.max_y        = DEF_HI;
			res_d.max_z        = DEF_HI;
			res_d.ctr_x        = '0;
			res_d.ctr_y        = '0;
			res_d.ctr_z        = '0;
			res_d.used_default = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res <= res_d;
		end
	end

endmodule
